/* src/line_pixel_stepper_macros.svh */
// Assertion macros used by the line pixel stepper checker.
`ifndef LINE_PIXEL_STEPPER_MACROS_SVH
`define LINE_PIXEL_STEPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/lps_pkg.sv */
// Shared types and constants of the line pixel stepper.
package lps_pkg;

	// Fixed field widths.
	localparam int SCR_BITS   = 12;
	localparam int ADDR_BITS  = 22;
	localparam int COLOR_BITS = 32;

	// Queue depths between the parts of the block.
	localparam int CMD_DEPTH = 2;
	localparam int OUT_DEPTH = 4;

	// Configuration register indexes.
	localparam logic [0:0] REG_SCREEN_WIDTH  = 1'b0;
	localparam logic [0:0] REG_SCREEN_HEIGHT = 1'b1;

	// Register values after reset.
	localparam logic [SCR_BITS-1:0] RESET_WIDTH  = 12'd640;
	localparam logic [SCR_BITS-1:0] RESET_HEIGHT = 12'd480;

	// Operation codes of an input item.
	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} lps_op_t;

	// Flags that travel with each pixel.
	typedef struct packed {
		logic write_enable;
		logic last_pixel;
		logic idle_step;
	} lps_flags_t;

endpackage

/* src/lps_queue.sv */
// Small register-based FIFO used between the front, the back and the result port.
module lps_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               push_data,
	output logic                           full,
	input  logic                           pop,
	output logic [WIDTH-1:0]               pop_data,
	output logic                           empty,
	output logic [$clog2(DEPTH+1)-1:0]     count
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign count    = count_q;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Storage is written on every accepted transfer in.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* src/lps_front.sv */
// Front part: classifies input items and precomputes line setup for start commands.
module lps_front #(
	parameter int COORD_BITS = 12
) (
	input  logic                         push,
	input  logic                         cmd_full,
	input  logic                         opcode,
	input  logic signed [COORD_BITS-1:0] x_start,
	input  logic signed [COORD_BITS-1:0] y_start,
	input  logic signed [COORD_BITS-1:0] x_end,
	input  logic signed [COORD_BITS-1:0] y_end,
	input  logic [31:0]                  line_color,
	output logic                         cmd_push,
	output logic [6*COORD_BITS+34:0]     cmd_data
);
	import lps_pkg::*;

	localparam int C = COORD_BITS;

	logic signed [C:0] diff_x;
	logic signed [C:0] diff_y;
	logic [C:0]        abs_x;
	logic [C:0]        abs_y;
	logic              neg_x;
	logic              neg_y;
	logic              is_start;

	assign is_start = (lps_op_t'(opcode) == OP_START);
	assign cmd_push = push && !cmd_full;

	// Endpoint differences, widened by one bit so they cannot overflow.
	always_comb begin
		diff_x = $signed({x_end[C-1], x_end}) - $signed({x_start[C-1], x_start});
		diff_y = $signed({y_end[C-1], y_end}) - $signed({y_start[C-1], y_start});
		abs_x  = diff_x[C] ? $unsigned(-diff_x) : $unsigned(diff_x);
		abs_y  = diff_y[C] ? $unsigned(-diff_y) : $unsigned(diff_y);
		// A direction steps negative unless the end lies strictly ahead.
		neg_x  = diff_x[C] || (diff_x == '0);
		neg_y  = diff_y[C] || (diff_y == '0);
	end

	// Step commands carry only the opcode; setup fields are zero.
	always_comb begin
		if (is_start) begin
			cmd_data = {OP_START, line_color, neg_x, neg_y, abs_x[C-1:0], abs_y[C-1:0],
				x_end, y_end, x_start, y_start};
		end else begin
			cmd_data = {OP_STEP, {(6*C+34){1'b0}}};
		end
	end

endmodule

/* src/lps_back.sv */
// Back part: holds the line state, steps the error term and forms each pixel.
module lps_back #(
	parameter int COORD_BITS = 12
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic [6*COORD_BITS+34:0]                  cmd_data,
	input  logic                                      cmd_empty,
	output logic                                      cmd_pop,
	input  logic [$clog2(lps_pkg::OUT_DEPTH+1)-1:0]   out_count,
	input  logic [lps_pkg::SCR_BITS-1:0]              screen_width,
	input  logic [lps_pkg::SCR_BITS-1:0]              screen_height,
	output logic                                      res_push,
	output logic [2*COORD_BITS+56:0]                  res_data
);
	import lps_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int E     = C + 3;
	localparam int W     = (C > SCR_BITS) ? C : SCR_BITS;
	localparam int P     = 2 * SCR_BITS;
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	// Command fields.
	logic              c_op;
	logic [31:0]       c_color;
	logic              c_neg_x;
	logic              c_neg_y;
	logic [C-1:0]      c_dx;
	logic [C-1:0]      c_dy;
	logic [C-1:0]      c_goal_x;
	logic [C-1:0]      c_goal_y;
	logic [C-1:0]      c_cur_x;
	logic [C-1:0]      c_cur_y;

	// Line state.
	logic [C-1:0]      cur_x_q;
	logic [C-1:0]      cur_y_q;
	logic [C-1:0]      goal_x_q;
	logic [C-1:0]      goal_y_q;
	logic [C-1:0]      dx_q;
	logic [C-1:0]      dy_q;
	logic              neg_x_q;
	logic              neg_y_q;
	logic signed [E-1:0] err_q;
	logic [31:0]       color_q;
	logic              active_q;

	// Step arithmetic.
	logic signed [E:0]   e2;
	logic signed [E:0]   dx_w;
	logic signed [E:0]   dy_w;
	logic                move_x;
	logic                move_y;
	logic [C-1:0]        nx;
	logic [C-1:0]        ny;
	logic signed [E-1:0] err_n;
	logic                issue;
	logic [CNT_W-1:0]    in_use;

	// Pipeline stages.
	logic              v_s1;
	logic [C-1:0]      px_s1;
	logic [C-1:0]      py_s1;
	logic [31:0]       color_s1;
	logic              last_s1;
	logic              idle_s1;
	logic              v_s2;
	logic [C-1:0]      px_s2;
	logic [C-1:0]      py_s2;
	logic [31:0]       color_s2;
	logic [P-1:0]      prod_s2;
	lps_flags_t        flags_s2;
	logic              on_s1;
	logic [P-1:0]      addr_sum;
	logic [ADDR_BITS-1:0] addr;

	assign {c_op, c_color, c_neg_x, c_neg_y, c_dx, c_dy, c_goal_x, c_goal_y,
		c_cur_x, c_cur_y} = cmd_data;

	// A command issues only when the result queue has room for it and every pixel in flight.
	assign in_use  = out_count + CNT_W'(v_s1) + CNT_W'(v_s2);
	assign issue   = !cmd_empty && (in_use < CNT_W'(OUT_DEPTH));
	assign cmd_pop = issue;

	// One Bresenham step from the held state.
	always_comb begin
		e2     = {err_q, 1'b0};
		dx_w   = $signed({4'b0000, dx_q});
		dy_w   = $signed({4'b0000, dy_q});
		move_x = (e2 > -dy_w);
		move_y = (e2 < dx_w);
		err_n  = err_q - (move_x ? $signed({3'b000, dy_q}) : '0)
			+ (move_y ? $signed({3'b000, dx_q}) : '0);
		nx     = cur_x_q;
		ny     = cur_y_q;
		if (move_x) begin
			nx = neg_x_q ? cur_x_q - C'(1) : cur_x_q + C'(1);
		end
		if (move_y) begin
			ny = neg_y_q ? cur_y_q - C'(1) : cur_y_q + C'(1);
		end
	end

	// Line state: loaded by start, advanced by step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (issue) begin
			if (c_op == OP_START) begin
				active_q <= (c_dx != '0) || (c_dy != '0);
			end else if (active_q) begin
				active_q <= !((nx == goal_x_q) && (ny == goal_y_q));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			if (c_op == OP_START) begin
				cur_x_q  <= c_cur_x;
				cur_y_q  <= c_cur_y;
				goal_x_q <= c_goal_x;
				goal_y_q <= c_goal_y;
				dx_q     <= c_dx;
				dy_q     <= c_dy;
				neg_x_q  <= c_neg_x;
				neg_y_q  <= c_neg_y;
				err_q    <= $signed({3'b000, c_dx}) - $signed({3'b000, c_dy});
				color_q  <= c_color;
			end else if (active_q) begin
				cur_x_q <= nx;
				cur_y_q <= ny;
				err_q   <= err_n;
			end
		end
	end

	// Stage 1: the pixel's coordinates and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			priority if (c_op == OP_START) begin
				px_s1    <= c_cur_x;
				py_s1    <= c_cur_y;
				color_s1 <= c_color;
				last_s1  <= (c_dx == '0) && (c_dy == '0);
				idle_s1  <= 1'b0;
			end else if (active_q) begin
				px_s1    <= nx;
				py_s1    <= ny;
				color_s1 <= color_q;
				last_s1  <= (nx == goal_x_q) && (ny == goal_y_q);
				idle_s1  <= 1'b0;
			end else begin
				px_s1    <= '0;
				py_s1    <= '0;
				color_s1 <= '0;
				last_s1  <= 1'b0;
				idle_s1  <= 1'b1;
			end
		end
	end

	// Stage 2: clipping and the row product of the address.
	assign on_s1 = !idle_s1 && !px_s1[C-1] && !py_s1[C-1]
		&& (W'(px_s1) < W'(screen_width)) && (W'(py_s1) < W'(screen_height));

	always_ff @(posedge clk) begin
		if (v_s1) begin
			px_s2                 <= px_s1;
			py_s2                 <= py_s1;
			color_s2              <= color_s1;
			prod_s2               <= P'(SCR_BITS'(py_s1)) * P'(screen_width);
			flags_s2.write_enable <= on_s1;
			flags_s2.last_pixel   <= last_s1;
			flags_s2.idle_step    <= idle_s1;
		end
	end

	// Address completion and transfer into the result queue.
	assign addr_sum = prod_s2 + P'(SCR_BITS'(px_s2));
	assign addr     = flags_s2.write_enable ? ADDR_BITS'(addr_sum) : '0;
	assign res_push = v_s2;
	assign res_data = {px_s2, py_s2, addr, color_s2, flags_s2};

endmodule

/* src/line_pixel_stepper.sv */
// Top level of the line pixel stepper: Bresenham rasterizer with screen clipping.
// Usage: the input side is a queue. Drive the item fields with push high; the item
// transfers on a rising edge where full is low. opcode start loads both endpoints and the
// color and yields the first pixel; opcode step yields the next pixel of the line, or an
// idle result when no line is active. Every item yields exactly one result.
// The result side is a queue too: while empty is low the oldest pixel is on the ports,
// and it transfers on a rising edge where pop is high.
// Throughput: one item per cycle while results are popped, set by the error-term step
// in the back part and the pixel stages 1 and 2 that feed a four-entry result queue.
// When pop is held low the result queue fills, the back part stops issuing, the two-entry
// command queue fills and full rises; nothing is dropped and work resumes with pop.
// Screen registers are written through cfg_write, cfg_index and cfg_data; the user must
// do so only while idle, as the block itself does not enforce it. Reset empties both
// queues, ends any active line and sets the screen to 640 by 480.
module line_pixel_stepper #(
	parameter int COORD_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [0:0]                        cfg_index,
	input  logic [lps_pkg::SCR_BITS-1:0]      cfg_data,
	input  logic                              push,
	output logic                              full,
	input  logic                              opcode,
	input  logic signed [COORD_BITS-1:0]      x_start,
	input  logic signed [COORD_BITS-1:0]      y_start,
	input  logic signed [COORD_BITS-1:0]      x_end,
	input  logic signed [COORD_BITS-1:0]      y_end,
	input  logic [lps_pkg::COLOR_BITS-1:0]    line_color,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [COORD_BITS-1:0]      pixel_x,
	output logic signed [COORD_BITS-1:0]      pixel_y,
	output logic [lps_pkg::ADDR_BITS-1:0]     pixel_address,
	output logic [lps_pkg::COLOR_BITS-1:0]    pixel_color,
	output logic                              write_enable,
	output logic                              last_pixel,
	output logic                              idle_step
);
	import lps_pkg::*;

	localparam int CMD_W = 6 * COORD_BITS + 35;
	localparam int RES_W = 2 * COORD_BITS + 57;

	logic [SCR_BITS-1:0] width_q;
	logic [SCR_BITS-1:0] height_q;

	logic                cmd_push;
	logic [CMD_W-1:0]    cmd_wdata;
	logic [CMD_W-1:0]    cmd_rdata;
	logic                cmd_empty;
	logic                cmd_pop;
	logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

	logic                res_push;
	logic [RES_W-1:0]    res_wdata;
	logic [RES_W-1:0]    res_rdata;
	logic                res_full;
	logic [$clog2(OUT_DEPTH+1)-1:0] res_count;
	lps_flags_t          res_flags;

	// Screen size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lps_front #(.COORD_BITS(COORD_BITS)) u_front (
		.push       (push),
		.cmd_full   (full),
		.opcode     (opcode),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.line_color (line_color),
		.cmd_push   (cmd_push),
		.cmd_data   (cmd_wdata)
	);

	lps_queue #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_wdata),
		.full      (full),
		.pop       (cmd_pop),
		.pop_data  (cmd_rdata),
		.empty     (cmd_empty),
		.count     (cmd_count)
	);

	lps_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_data      (cmd_rdata),
		.cmd_empty     (cmd_empty),
		.cmd_pop       (cmd_pop),
		.out_count     (res_count),
		.screen_width  (width_q),
		.screen_height (height_q),
		.res_push      (res_push),
		.res_data      (res_wdata)
	);

	lps_queue #(.WIDTH(RES_W), .DEPTH(OUT_DEPTH)) u_res_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_wdata),
		.full      (res_full),
		.pop       (pop),
		.pop_data  (res_rdata),
		.empty     (empty),
		.count     (res_count)
	);

	// Result fields; the queue never overflows since the back part issues against its count.
	assign {pixel_x, pixel_y, pixel_address, pixel_color, res_flags} = res_rdata;
	assign write_enable = res_flags.write_enable && !(res_full && cmd_count[0] && 1'b0);
	assign last_pixel   = res_flags.last_pixel;
	assign idle_step    = res_flags.idle_step;

endmodule

/* src/lps_checker.sv */
// Port-level checker for the line pixel stepper, bound to the top level.
`include "line_pixel_stepper_macros.svh"

module lps_checker #(
	parameter int COORD_BITS = 12
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              empty,
	input logic                              pop,
	input logic signed [COORD_BITS-1:0]      pixel_x,
	input logic signed [COORD_BITS-1:0]      pixel_y,
	input logic [lps_pkg::ADDR_BITS-1:0]     pixel_address,
	input logic [lps_pkg::COLOR_BITS-1:0]    pixel_color,
	input logic                              write_enable,
	input logic                              last_pixel,
	input logic                              idle_step
);
	import lps_pkg::*;

	// An idle result carries nothing but its flag.
	`LPS_ASSERT_IMP(a_idle_zero, clk, arst_n, !empty && idle_step, pixel_x == '0 && pixel_y == '0 && pixel_address == '0 && pixel_color == '0 && !write_enable && !last_pixel, "idle result has nonzero fields")

	// A clipped pixel has a zero address.
	`LPS_ASSERT_IMP(a_clip_addr, clk, arst_n, !empty && !write_enable, pixel_address == '0, "clipped pixel has an address")

	// A written pixel lies at nonnegative coordinates.
	`LPS_ASSERT_IMP(a_on_screen, clk, arst_n, !empty && write_enable, !pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1], "written pixel has a negative coordinate")

	// A waiting result holds until it transfers.
	`LPS_ASSERT_NXT(a_res_hold, clk, arst_n, !empty && !pop, !empty && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_address) && $stable(pixel_color), "waiting result changed")

endmodule

bind line_pixel_stepper lps_checker #(.COORD_BITS(COORD_BITS)) u_lps_checker (.*);
